// ===== design/gcd_pkg.sv =====
// Shared constants, tables and types for the great-circle distance pipeline.
`default_nettype none

package gcd_pkg;

  // Default number of fraction bits in the degree inputs
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 22;

  // CORDIC datapath
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Degree to turn conversion: 360 = 8 * 45, quotient by 45 via reciprocal
  localparam int unsigned DIV_BASE     = 45;
  localparam int unsigned QUO_W        = 27;
  localparam int unsigned REM_W        = 6;
  localparam logic [31:0] RECIP45      = 32'd3054198966;
  localparam int unsigned RECIP45_SHR  = 37;

  // Haversine term and square root
  localparam int unsigned HY_W         = 31;
  localparam logic [HY_W-1:0] ONE_Q30  = 31'h4000_0000;
  localparam int unsigned SQ_STEPS     = 31;
  localparam int unsigned SQ_W         = 62;

  // pi in Q2.29
  localparam logic [30:0] PI_Q29       = 31'd1686629713;

  // Fraction table: (b * 2^shift + 180) / 360 for each remainder b < 45
  typedef logic [31:0] frac_tbl_t [DIV_BASE];

  function automatic frac_tbl_t frac_tbl(input int unsigned shift);
    frac_tbl_t t;
    for (int b = 0; b < DIV_BASE; b++) begin
      t[b] = 32'(((longint'(b) << shift) + 64'd180) / 64'd360);
    end
    return t;
  endfunction

  // atan(2^-i) in turns, Q0.32
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      24:      a = 32'h0000_0029;
      25:      a = 32'h0000_0014;
      26:      a = 32'h0000_000A;
      27:      a = 32'h0000_0005;
      28:      a = 32'h0000_0003;
      29:      a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== design/gcd_cordic_rot.sv =====
// Pipelined rotation CORDIC giving the sine or cosine of a turn angle.
`default_nettype none

module gcd_cordic_rot (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               sel_cos_i,
  input  logic [31:0]        angle_i,
  output logic signed [31:0] result_o
);

  localparam int unsigned N = gcd_pkg::CORDIC_STEPS;
  localparam int unsigned W = gcd_pkg::CW;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  logic [1:0]          quad_q [N+1];

  logic [31:0] rot_sum;
  logic [31:0] resid;
  logic [1:0]  quad_d;
  logic signed [W-1:0] res_d;
  logic signed [31:0]  result_q;

  // quadrant from the angle plus one eighth turn, residual in [-1/8, 1/8)
  assign rot_sum = angle_i + 32'h2000_0000;
  assign quad_d  = rot_sum[31:30];
  assign resid   = angle_i - {quad_d, 30'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= gcd_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= W'(signed'(resid));
      quad_q[0] <= quad_d;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [W-1:0] AT = W'(gcd_pkg::atan_turn(i));
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - AT;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + AT;
        end
      end
    end
  end

  // quadrant fold-back
  always_comb begin
    case (quad_q[N])
      2'd0:    res_d = sel_cos_i ?  x_q[N] :  y_q[N];
      2'd1:    res_d = sel_cos_i ? -y_q[N] :  x_q[N];
      2'd2:    res_d = sel_cos_i ? -x_q[N] : -y_q[N];
      default: res_d = sel_cos_i ?  y_q[N] : -x_q[N];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= res_d[31:0];
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== design/gcd_isqrt.sv =====
// Pipelined digit-by-digit square root, floor(sqrt(v * 2^30)), one bit per stage.
`default_nettype none

module gcd_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [gcd_pkg::HY_W-1:0]   rad_i,
  output logic [gcd_pkg::HY_W-1:0]   root_o
);

  localparam int unsigned S  = gcd_pkg::SQ_STEPS;
  localparam int unsigned VW = gcd_pkg::SQ_W;

  logic [VW-1:0] v_w [S+1];
  logic [VW-1:0] r_w [S+1];
  logic [VW-1:0] v_q [S];
  logic [VW-1:0] r_q [S];

  assign v_w[0] = VW'({rad_i, 30'b0});
  assign r_w[0] = '0;

  for (genvar k = 0; k < S; k++) begin : g_bit
    localparam logic [VW-1:0] BIT = VW'(1) << (2 * (S - 1 - k));
    logic [VW-1:0] trial;
    assign trial = r_w[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_w[k] >= trial) begin
          v_q[k] <= v_w[k] - trial;
          r_q[k] <= (r_w[k] >> 1) + BIT;
        end else begin
          v_q[k] <= v_w[k];
          r_q[k] <= r_w[k] >> 1;
        end
      end
    end

    assign v_w[k+1] = v_q[k];
    assign r_w[k+1] = r_q[k];
  end

  assign root_o = r_w[S][gcd_pkg::HY_W-1:0];

endmodule

`default_nettype wire

// ===== design/great_circle_distance.sv =====
// Great-circle central angle (haversine) between two points, fully pipelined.
//
// Input channel: in_valid_i / in_ready_o carry one point pair, latitudes and
// longitudes in signed degrees scaled by 2^ANGLE_FRAC_BITS. Output channel:
// out_valid_o / out_ready_i carry the central angle in radians, unsigned
// Q2.30, 0 to pi.
// From input transfer to output valid a pair passes through 4 stages of
// degree-to-turn conversion, 32 of rotation CORDIC, 3 of products, 31 of
// square root (one root bit per stage), 30 of vectoring CORDIC and one
// output multiply. Throughput is one pair per cycle unless the output stalls.
// Every stage advances together. When a result waits at the output and the
// receiver holds out_ready_i low, the whole pipe freezes and in_ready_o
// drops; nothing is lost or repeated. Reset clears the valid bits only; the
// block keeps no other state.
`default_nettype none

module great_circle_distance #(
  parameter int unsigned ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [29:0] first_lat_i,
  input  logic signed [30:0] first_lon_i,
  input  logic signed [29:0] second_lat_i,
  input  logic signed [30:0] second_lon_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        central_angle_o
);

  localparam int unsigned SH_HALF = 31 - ANGLE_FRAC_BITS;
  localparam int unsigned SH_FULL = 32 - ANGLE_FRAC_BITS;
  localparam int unsigned LANES   = 4;
  localparam int unsigned N       = gcd_pkg::CORDIC_STEPS;
  localparam int unsigned W       = gcd_pkg::CW;
  localparam int unsigned QW      = gcd_pkg::QUO_W;
  localparam int unsigned RW      = gcd_pkg::REM_W;
  localparam int unsigned HW      = gcd_pkg::HY_W;
  localparam int unsigned DEPTH   = 4 + (N + 2) + 3 + gcd_pkg::SQ_STEPS + N + 1;

  logic adv;
  logic [DEPTH-1:0] vld_q;

  // global advance: the pipe moves unless the output holds a stalled result
  assign adv        = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- front end
  // lane 0: lat difference, 1: lon difference, 2: lat1, 3: lat2
  logic signed [31:0] dval [LANES];
  logic [31:0]        mag_d [LANES];

  assign dval[0] = 32'(second_lat_i) - 32'(first_lat_i);
  assign dval[1] = 32'(second_lon_i) - 32'(first_lon_i);
  assign dval[2] = 32'(first_lat_i);
  assign dval[3] = 32'(second_lat_i);

  logic [31:0]   mag_q   [LANES];
  logic [31:0]   mag2_q  [LANES];
  logic [QW-1:0] aest_q  [LANES];
  logic [QW-1:0] quo_q   [LANES];
  logic [RW-1:0] rem_q   [LANES];
  logic [31:0]   turn_q  [LANES];
  logic signed [31:0] trig [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int unsigned SH = (l < 2) ? SH_HALF : SH_FULL;
    localparam gcd_pkg::frac_tbl_t TBL = gcd_pkg::frac_tbl(SH);

    logic [63:0]   recip_prod;
    logic [31:0]   rem_raw;
    logic [39:0]   quo_shl;

    assign mag_d[l]   = dval[l][31] ? 32'(-dval[l]) : 32'(dval[l]);
    assign recip_prod = 64'(mag_q[l]) * 64'(gcd_pkg::RECIP45);
    assign rem_raw    = mag2_q[l] - 32'(aest_q[l]) * 32'(gcd_pkg::DIV_BASE);
    assign quo_shl    = 40'(quo_q[l]) << (SH - 3);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // magnitude
        mag_q[l]  <= mag_d[l];
        // quotient estimate by 45, low by at most one
        aest_q[l] <= recip_prod[gcd_pkg::RECIP45_SHR +: QW];
        mag2_q[l] <= mag_q[l];
        // one correction step
        if (rem_raw >= 32'(gcd_pkg::DIV_BASE)) begin
          quo_q[l] <= aest_q[l] + QW'(1);
          rem_q[l] <= RW'(rem_raw - 32'(gcd_pkg::DIV_BASE));
        end else begin
          quo_q[l] <= aest_q[l];
          rem_q[l] <= RW'(rem_raw);
        end
        // turns = quo * 2^(shift-3) + rounded fraction of the remainder
        turn_q[l] <= quo_shl[31:0] + TBL[rem_q[l]];
      end
    end

    gcd_cordic_rot u_rot (
      .clk_i     (clk_i),
      .en_i      (adv),
      .sel_cos_i (l >= 2),
      .angle_i   (turn_q[l]),
      .result_o  (trig[l])
    );
  end

  // ---------------------------------------------------------------- products
  logic signed [63:0] p_lat;
  logic signed [63:0] p_lon;
  logic signed [63:0] p_cc;
  logic signed [33:0] hy1_q;
  logic signed [33:0] t_q;
  logic signed [33:0] cc_q;
  logic signed [67:0] p_tcc;
  logic signed [33:0] hy1b_q;
  logic signed [37:0] tcc_q;
  logic signed [38:0] hy_sum;
  logic [HW-1:0]      hy_q;
  logic [HW-1:0]      hyc;

  assign p_lat  = 64'(trig[0]) * 64'(trig[0]);
  assign p_lon  = 64'(trig[1]) * 64'(trig[1]);
  assign p_cc   = 64'(trig[2]) * 64'(trig[3]);
  assign p_tcc  = 68'(t_q) * 68'(cc_q);
  assign hy_sum = 39'(hy1b_q) + 39'(tcc_q);
  assign hyc    = gcd_pkg::ONE_Q30 - hy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hy1_q  <= p_lat[63:30];
      t_q    <= p_lon[63:30];
      cc_q   <= p_cc[63:30];
      hy1b_q <= hy1_q;
      tcc_q  <= p_tcc[67:30];
      // clamp haversine term to [0, 1]
      if (hy_sum[38]) begin
        hy_q <= '0;
      end else if (hy_sum > 39'(gcd_pkg::ONE_Q30)) begin
        hy_q <= gcd_pkg::ONE_Q30;
      end else begin
        hy_q <= hy_sum[HW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- roots
  logic [HW-1:0] root_s;
  logic [HW-1:0] root_c;

  gcd_isqrt u_sqrt_s (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (hy_q),
    .root_o (root_s)
  );

  gcd_isqrt u_sqrt_c (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (hyc),
    .root_o (root_c)
  );

  // ---------------------------------------------------------------- atan2
  logic signed [W-1:0] vx_w [N+1];
  logic signed [W-1:0] vy_w [N+1];
  logic signed [W-1:0] vz_w [N+1];
  logic signed [W-1:0] vx_q [N];
  logic signed [W-1:0] vy_q [N];
  logic signed [W-1:0] vz_q [N];

  assign vx_w[0] = signed'(W'(root_c));
  assign vy_w[0] = signed'(W'(root_s));
  assign vz_w[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [W-1:0] AT = W'(gcd_pkg::atan_turn(i));
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    assign dx = vy_w[i] >>> i;
    assign dy = vx_w[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (vy_w[i][W-1]) begin
          vx_q[i] <= vx_w[i] - dx;
          vy_q[i] <= vy_w[i] + dy;
          vz_q[i] <= vz_w[i] - AT;
        end else if (vy_w[i] != '0) begin
          vx_q[i] <= vx_w[i] + dx;
          vy_q[i] <= vy_w[i] - dy;
          vz_q[i] <= vz_w[i] + AT;
        end else begin
          vx_q[i] <= vx_w[i];
          vy_q[i] <= vy_w[i];
          vz_q[i] <= vz_w[i];
        end
      end
    end

    assign vx_w[i+1] = vx_q[i];
    assign vy_w[i+1] = vy_q[i];
    assign vz_w[i+1] = vz_q[i];
  end

  // ---------------------------------------------------------------- output
  // clamp to a quarter turn, times 4*pi (twice the half angle), rounded to Q2.30
  logic [HW-1:0] z_clamp;
  logic [61:0]   ang_prod;
  logic [31:0]   angle_q;

  always_comb begin
    if (vz_w[N][W-1]) begin
      z_clamp = '0;
    end else if (vz_w[N] > W'(gcd_pkg::ONE_Q30)) begin
      z_clamp = gcd_pkg::ONE_Q30;
    end else begin
      z_clamp = vz_w[N][HW-1:0];
    end
  end

  assign ang_prod = 62'(z_clamp) * 62'(gcd_pkg::PI_Q29) + 62'(1 << 28);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q <= ang_prod[60:29];
    end
  end

  assign out_valid_o     = vld_q[DEPTH-1];
  assign central_angle_o = angle_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the great-circle distance pipeline.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC      = 22;
  localparam int unsigned LATENCY   = 101;
  localparam int          LAT_MAX   = 377487360;
  localparam int          LON_MAX   = 754974720;
  localparam longint      ONE       = 64'sd1 << 30;
  localparam longint      GAIN      = 64'sd652032874;
  localparam longint      PI29      = 64'sd1686629713;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [29:0] first_lat;
  logic signed [30:0] first_lon;
  logic signed [29:0] second_lat;
  logic signed [30:0] second_lon;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        central_angle;

  // Idle percentages and hold-off control
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  int unsigned n_errors;
  int unsigned n_checked;
  int unsigned n_sent;
  logic [31:0] angle_queue[$];

  great_circle_distance #(.ANGLE_FRAC_BITS(FRAC)) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .first_lat_i    (first_lat),
    .first_lon_i    (first_lon),
    .second_lat_i   (second_lat),
    .second_lon_i   (second_lon),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .central_angle_o(central_angle)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // Arithmetic right shift, floor
  function automatic longint asr(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] atan_step(input int unsigned i);
    logic [31:0] tbl [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    return tbl[i];
  endfunction

  // Degree magnitude to turns, rounded half up, wrapped to 32 bits
  function automatic logic [31:0] to_turns(input longint d, input int unsigned sh);
    longint unsigned mag;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    return 32'(((mag << sh) + 64'd180) / 64'd360);
  endfunction

  // Rotation CORDIC with quadrant folding
  task automatic rotate(input logic [31:0] a, output longint s, output longint c);
    logic [31:0] quad;
    logic [31:0] r;
    longint      x, y, z, dx, dy;
    quad = ((a + 32'h20000000) >> 30) & 32'd3;
    r    = a - (quad << 30);
    z    = longint'($signed(r));
    x    = GAIN;
    y    = 0;
    for (int i = 0; i < 30; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_step(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_step(i));
      end
    end
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Expected central angle for one point pair
  task automatic predict_angle(input logic signed [29:0] la1, input logic signed [30:0] lo1,
                               input logic signed [29:0] la2, input logic signed [30:0] lo2,
                               output logic [31:0] angle);
    longint s_lat, s_lon, c1, c2, unused, hy, t, cc, rs, rc, x, y, z, dx, dy;
    longint unsigned prod;
    rotate(to_turns(longint'(la2) - longint'(la1), 31 - FRAC), s_lat, unused);
    rotate(to_turns(longint'(lo2) - longint'(lo1), 31 - FRAC), s_lon, unused);
    rotate(to_turns(longint'(la1), 32 - FRAC), unused, c1);
    rotate(to_turns(longint'(la2), 32 - FRAC), unused, c2);
    hy = asr(s_lat * s_lat, 30);
    t  = asr(s_lon * s_lon, 30);
    cc = asr(c1 * c2, 30);
    hy += asr(t * cc, 30);
    if (hy < 0) hy = 0;
    if (hy > ONE) hy = ONE;
    rs = longint'(int_sqrt(longint'(hy) << 30));
    rc = longint'(int_sqrt(longint'(ONE - hy) << 30));
    // Vectoring CORDIC
    x = rc; y = rs; z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_step(i));
      end else if (y < 0) begin
        x -= dx; y += dy; z -= longint'(atan_step(i));
      end
    end
    if (z < 0) z = 0;
    if (z > ONE) z = ONE;
    prod  = (longint'(z) * PI29 + (64'd1 << 28)) >> 29;
    angle = prod[31:0];
  endtask

  // Offer one pair and wait for its transfer; valid stays up for a following pair
  task automatic send_pair(input logic signed [29:0] la1, input logic signed [30:0] lo1,
                           input logic signed [29:0] la2, input logic signed [30:0] lo2);
    logic [31:0] angle;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    predict_angle(la1, lo1, la2, lo2, angle);
    first_lat  <= la1;
    first_lon  <= lo1;
    second_lat <= la2;
    second_lon <= lo2;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    angle_queue.push_back(angle);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [29:0] rand_lat();
    return 30'($signed($urandom_range(2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic signed [30:0] rand_lon();
    return 31'(longint'($urandom_range(2 * LON_MAX)) - LON_MAX);
  endfunction

  // Stop offering and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (angle_queue.size() != 0) @(negedge clk);
  endtask

  // Extremes, poles, antipodes and identical points
  task automatic test_directed();
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX);
    send_pair(123456789, 98765432, 123456789, 98765432);
    send_pair(0, 0, 0, 1);
    send_pair(1, 0, 0, 0);
    send_pair(45 << FRAC, 10 << FRAC, -(45 << FRAC), -(170 << FRAC));
    // Beyond the stated range: full field extremes, wrapping trig
    send_pair(30'h1FFFFFFF, 31'h3FFFFFFF, 30'sh20000000, 31'sh40000000);
    send_pair(30'sh20000000, 31'sh40000000, 30'h1FFFFFFF, 31'h3FFFFFFF);
    send_pair(30'h3FFFFFFF, 31'h7FFFFFFF, 30'h15555555, 31'h2AAAAAAA);
    send_pair(30'h2AAAAAAA, 31'h55555555, 30'h00000000, 31'h00000000);
    send_pair(100 << FRAC, 0, 100 << FRAC, 180 << FRAC);
    send_pair(LAT_MAX, 0, LAT_MAX - 1, 0);
    drain();
  endtask

  // Random pairs: mostly in range, some close pairs, some raw field values
  task automatic test_random(input int unsigned count);
    logic signed [29:0] la1, la2;
    logic signed [30:0] lo1, lo2;
    for (int unsigned k = 0; k < count; k++) begin
      la1 = rand_lat();
      lo1 = rand_lon();
      case ($urandom_range(9))
        0: begin la2 = 30'($urandom); lo2 = 31'($urandom); la1 = 30'($urandom); end
        1, 2: begin
          la2 = la1 + 30'($signed($urandom_range(2000)) - 1000);
          lo2 = lo1 + 31'($signed($urandom_range(2000)) - 1000);
        end
        default: begin la2 = rand_lat(); lo2 = rand_lon(); end
      endcase
      send_pair(la1, lo1, la2, lo2);
    end
  endtask

  // Receiver holds off long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    hold_cycles = 3 * LATENCY;
    test_random(200);
    drain();
  endtask

  // Output checker and receiver stall generator
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (angle_queue.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result %0d", central_angle);
      end else begin
        logic [31:0] exp_angle;
        exp_angle = angle_queue.pop_front();
        n_checked++;
        if (central_angle !== exp_angle) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Mismatch central_angle: expected %0d actual %0d", exp_angle,
                     central_angle);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    in_valid       = 1'b0;
    first_lat      = '0;
    first_lon      = '0;
    second_lat     = '0;
    second_lon     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    n_errors       = 0;
    n_checked      = 0;
    n_sent         = 0;
    rst_n          = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(450);
    send_idle_pct = 67;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    test_random(400);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();

    repeat (LATENCY + 20) @(negedge clk);
    $display("Sent %0d point pairs, checked %0d angles across idle and stall phases,",
             n_sent, n_checked);
    $display("including a long output hold-off; %0d errors", n_errors);
    if (n_errors == 0 && angle_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
